// ===== sv/htfc_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the humidity and
// temperature frame checker. Used by every module of the block; no dependencies.
package htfc_pkg;

  localparam int unsigned PROD_W = 27;
  localparam int unsigned QUOT_W = 11;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [10:0] TEMP_SCALE = 11'd1750;
  localparam logic [10:0] HUM_SCALE_NARROW = 11'd1000;
  localparam logic [10:0] HUM_SCALE_WIDE = 11'd1250;
  localparam logic [PROD_W-1:0] ROUND_HALF = 27'd32768;
  localparam logic signed [12:0] TEMP_BIAS = 13'sd450;
  localparam logic signed [11:0] HUM_BIAS = 12'sd60;
  localparam logic signed [11:0] HUM_MAX = 12'sd1000;

  localparam logic [3:0] ADDR_HUM_MODE = 4'h0;
  localparam logic [3:0] ADDR_TEMP_OFFSET = 4'h4;
  localparam logic [3:0] ADDR_HUM_OFFSET = 4'h8;

  localparam logic [1:0] STATUS_TEMP_BAD = 2'b01;
  localparam logic [1:0] STATUS_HUM_BAD = 2'b10;

  typedef struct packed {
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic [7:0]  check_t;
    logic [7:0]  check_h;
    logic [7:0]  crc_t;
    logic [7:0]  crc_h;
  } front_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod_t;
    logic [PROD_W-1:0] prod_h;
    logic              wide_mode;
    logic [1:0]        status;
  } scaled_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/htfc_crc_front.sv =====
// First pipeline stage: registers the frame and runs the CRC-8 over the high
// byte of each word. Depends on htfc_pkg.
module htfc_crc_front import htfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [47:0] up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output front_t      dn_data
);

  logic   valid_r;
  front_t data_r;
  front_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt.raw_t   = {up_data[7:0], up_data[15:8]};
    data_nxt.check_t = up_data[23:16];
    data_nxt.raw_h   = {up_data[31:24], up_data[39:32]};
    data_nxt.check_h = up_data[47:40];
    data_nxt.crc_t   = crc8_byte(CRC_INIT, up_data[7:0]);
    data_nxt.crc_h   = crc8_byte(CRC_INIT, up_data[31:24]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== sv/htfc_check_mul.sv =====
// Second pipeline stage: finishes both CRCs, sets the status bits and scales
// the raw words by their constant factors. Depends on htfc_pkg.
module htfc_check_mul import htfc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wide_mode,
  input  logic    up_valid,
  output logic    up_ready,
  input  front_t  up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output scaled_t dn_data
);

  logic       valid_r;
  scaled_t    data_r;
  scaled_t    data_nxt;
  logic [7:0] crc_t;
  logic [7:0] crc_h;
  logic [10:0] hum_scale;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    crc_t = crc8_byte(up_data.crc_t, up_data.raw_t[7:0]);
    crc_h = crc8_byte(up_data.crc_h, up_data.raw_h[7:0]);
    hum_scale = wide_mode ? HUM_SCALE_WIDE : HUM_SCALE_NARROW;
    data_nxt.status = ((crc_t != up_data.check_t) ? STATUS_TEMP_BAD : 2'b00)
                    | ((crc_h != up_data.check_h) ? STATUS_HUM_BAD : 2'b00);
    data_nxt.prod_t = PROD_W'(up_data.raw_t * TEMP_SCALE);
    data_nxt.prod_h = PROD_W'(up_data.raw_h * hum_scale);
    data_nxt.wide_mode = wide_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== sv/htfc_convert.sv =====
// Third pipeline stage and output register: rounds the products, applies the
// biases, clamp and calibration offsets, and zeroes values of failed frames.
// Depends on htfc_pkg.
module htfc_convert import htfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [10:0] temp_offset,
  input  logic signed [7:0]  hum_offset,
  input  logic               up_valid,
  output logic               up_ready,
  input  scaled_t            up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic signed [12:0] dn_temp,
  output logic signed [11:0] dn_hum,
  output logic [1:0]         dn_status
);

  logic               valid_r;
  logic signed [12:0] temp_r;
  logic signed [11:0] hum_r;
  logic [1:0]         status_r;
  logic signed [12:0] temp_nxt;
  logic signed [11:0] hum_nxt;
  logic [PROD_W-1:0]  sum_t;
  logic [PROD_W-1:0]  sum_h;
  logic [QUOT_W-1:0]  quot_t;
  logic [QUOT_W-1:0]  quot_h;
  logic signed [11:0] hum_raw;
  logic signed [11:0] hum_clamp;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    sum_t  = up_data.prod_t + ROUND_HALF;
    sum_h  = up_data.prod_h + ROUND_HALF;
    quot_t = sum_t[PROD_W-1:16];
    quot_h = sum_h[PROD_W-1:16];
    hum_raw = $signed({1'b0, quot_h});
    if (up_data.wide_mode) begin
      hum_raw = hum_raw - HUM_BIAS;
    end
    if (hum_raw < 12'sd0) begin
      hum_clamp = 12'sd0;
    end else if (hum_raw > HUM_MAX) begin
      hum_clamp = HUM_MAX;
    end else begin
      hum_clamp = hum_raw;
    end
    if (up_data.status != 2'b00) begin
      temp_nxt = 13'sd0;
      hum_nxt  = 12'sd0;
    end else begin
      temp_nxt = $signed({2'b00, quot_t}) - TEMP_BIAS + 13'(temp_offset);
      hum_nxt  = hum_clamp + 12'(hum_offset);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
      status_r <= up_data.status;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_temp   = temp_r;
  assign dn_hum    = hum_r;
  assign dn_status = status_r;

endmodule

// ===== sv/humidity_temp_frame_check_convert.sv =====
// Top level of the humidity and temperature frame checker and converter.
// Instantiates htfc_crc_front, htfc_check_mul and htfc_convert; uses htfc_pkg.
//
// Usage: each input item is one six-byte sensor frame on in_tdata. Each
// 16-bit word is checked against its CRC-8 (polynomial 0x31, init 0xFF) and,
// when both pass, converted to tenths of a degree and tenths of a percent.
// Every frame gives exactly one result item on out_tdata, with the failure
// flags on out_tuser; values of a failed frame are zero.
// Three register stages lie between acceptance and out_tvalid (CRC front half,
// CRC finish with constant multiply, and rounding with clamp and offsets).
// One item is accepted every cycle while out_tready is high.
// When the receiver stalls, the full stages hold their items and in_tready
// drops only once every stage is occupied; no item is lost or repeated.
// Reset empties the pipeline and clears the scale mode and both offsets.
// Registers: 0x0 humidity scale mode, 0x4 temperature offset, 0x8 humidity
// offset. Write them only while no item is in flight.
module humidity_temp_frame_check_convert import htfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // temp_high_byte, temp_low_byte, temp_check_byte, hum_high_byte,
  // hum_low_byte, hum_check_byte
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // temperature_tenths [12:0], humidity_tenths [24:13], zeros above
  output logic [31:0] out_tdata,
  // frame_status [1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic               hum_mode_r;
  logic signed [10:0] temp_offset_r;
  logic signed [7:0]  hum_offset_r;
  logic               cfg_write;

  logic               s1_valid;
  logic               s1_ready;
  front_t             s1_data;
  logic               s2_valid;
  logic               s2_ready;
  scaled_t            s2_data;
  logic signed [12:0] temp_out;
  logic signed [11:0] hum_out;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hum_mode_r    <= 1'b0;
      temp_offset_r <= 11'sd0;
      hum_offset_r  <= 8'sd0;
    end else if (cfg_write) begin
      case (cfg_paddr)
        ADDR_HUM_MODE:    hum_mode_r    <= cfg_pwdata[0];
        ADDR_TEMP_OFFSET: temp_offset_r <= $signed(cfg_pwdata[10:0]);
        ADDR_HUM_OFFSET:  hum_offset_r  <= $signed(cfg_pwdata[7:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_HUM_MODE:    cfg_prdata = {31'd0, hum_mode_r};
      ADDR_TEMP_OFFSET: cfg_prdata = {21'd0, temp_offset_r};
      ADDR_HUM_OFFSET:  cfg_prdata = {24'd0, hum_offset_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  htfc_crc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  htfc_check_mul u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .wide_mode (hum_mode_r),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .up_data   (s1_data),
    .dn_valid  (s2_valid),
    .dn_ready  (s2_ready),
    .dn_data   (s2_data)
  );

  htfc_convert u_convert (
    .clk         (clk),
    .rst_n       (rst_n),
    .temp_offset (temp_offset_r),
    .hum_offset  (hum_offset_r),
    .up_valid    (s2_valid),
    .up_ready    (s2_ready),
    .up_data     (s2_data),
    .dn_valid    (out_tvalid),
    .dn_ready    (out_tready),
    .dn_temp     (temp_out),
    .dn_hum      (hum_out),
    .dn_status   (out_tuser)
  );

  assign out_tdata = {7'd0, hum_out, temp_out};

endmodule
